// File: rtl/core/rrcs_pkg.sv
// Package for the round-robin configuration scheduler.
// Holds the payload structs, mode and status codes and shared constants.
// No dependencies.
package rrcs_pkg;

  localparam int unsigned MaxConfigsDef = 16;
  localparam int unsigned IdBitsDef     = 8;
  localparam int unsigned CountBitsDef  = 8;
  localparam int unsigned TimeBits      = 50;
  localparam int unsigned CfgIdxBits    = 1;

  localparam logic [2:0] ModeAdd     = 3'd0;
  localparam logic [2:0] ModeFinish  = 3'd1;
  localparam logic [2:0] ModeSched   = 3'd2;
  localparam logic [2:0] ModePreempt = 3'd3;
  localparam logic [2:0] ModeResume  = 3'd4;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  localparam logic [CfgIdxBits-1:0] RegTimeslice = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegKillMode  = 1'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  config_id;
    logic [47:0] now;
    logic [31:0] preempt_time;
    logic [31:0] store_time;
    logic [31:0] resume_time;
    logic [31:0] load_time;
  } in_item_t;

  typedef struct packed {
    logic        issued;
    logic [7:0]  next_config;
    logic        wait_valid;
    logic [31:0] wait_time;
    logic        wake_component;
    logic [1:0]  status;
  } out_item_t;

  // Saturate a 52-bit signed value to the 50-bit signed range.
  function automatic logic signed [TimeBits-1:0] sat50(input logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sd562949953421311;
    lo = -52'sd562949953421312;
    if (v > hi) sat50 = hi[TimeBits-1:0];
    else if (v < lo) sat50 = lo[TimeBits-1:0];
    else sat50 = v[TimeBits-1:0];
  endfunction

endpackage

// File: rtl/core/rrcs_ring.sv
// Ring memory of configuration ids and task counts.
// One synchronous memory, one registered read port, one write port.
// Depends on rrcs_pkg.
module rrcs_ring #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  import rrcs_pkg::*;

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

// File: rtl/core/round_robin_config_scheduler.sv
// Round-robin configuration scheduler. Items arrive on a valid/stall input channel
// and every item gives exactly one result item; the input stalls from acceptance
// until that result is taken, so items are handled one at a time. The timeslice
// and kill_mode registers are to be written through the cfg_ port only while no
// item is in flight; the block itself does not enforce this. Preemption, resume,
// unused modes and a schedule event that does not switch go straight to the result
// state. An add or finish searches the ring memory one entry a cycle, and a removal
// then shifts each tail entry up one place. A switching schedule event rotates the
// ring one entry at a time and then reads the new front.
// Depends on rrcs_pkg and rrcs_ring.
module round_robin_config_scheduler
  import rrcs_pkg::*;
#(
  parameter int unsigned MAX_CONFIGS = MaxConfigsDef,
  parameter int unsigned ID_BITS     = IdBitsDef,
  parameter int unsigned COUNT_BITS  = CountBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rrcs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrcs_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [rrcs_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);
  localparam int unsigned AW = $clog2(MAX_CONFIGS);
  localparam int unsigned LW = $clog2(MAX_CONFIGS + 1);
  localparam int unsigned EW = ID_BITS + COUNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_ROTATE, S_FRONT, S_DONE
  } state_t;

  state_t state_r;
  in_item_t item_r;
  out_item_t res_r;
  logic out_valid_r;
  logic [31:0] timeslice_r;
  logic kill_mode_r;
  logic [LW-1:0] len_r;
  logic sched_v_r, act_v_r;
  logic [ID_BITS-1:0] sched_id_r, act_id_r;
  logic signed [TimeBits-1:0] rem_r, last_r;
  logic [AW-1:0] idx_r;
  logic rd_wait_r;
  logic [EW-1:0] hold_r;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  logic [ID_BITS-1:0] id_in;
  logic [ID_BITS-1:0] rd_id;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic signed [TimeBits-1:0] charged;
  logic signed [51:0] ovh;
  logic [LW-1:0] idx_ext;

  assign id_in  = ID_BITS'(item_r.config_id);
  assign rd_id  = rd_data[EW-1:COUNT_BITS];
  assign rd_cnt = rd_data[COUNT_BITS-1:0];
  assign idx_ext = LW'(idx_r);
  assign charged = sat50(52'(signed'(rem_r)) - (52'(signed'({2'b0, item_r.now}))
                   - 52'(signed'(last_r))));
  assign ovh = 52'(signed'({2'b0, item_r.now})) + 52'(item_r.preempt_time)
             + 52'(item_r.resume_time) + 52'(item_r.load_time)
             + (kill_mode_r ? 52'd0 : 52'(item_r.store_time));

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  rrcs_ring #(.Depth(MAX_CONFIGS), .Width(EW)) u_ring (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Memory port control: reads walk idx_r; writes happen in the clocked block's cycle.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_data;
    rd_addr = idx_r;
    unique case (state_r)
      S_SEARCH: begin
        if (!rd_wait_r && len_r != '0 && rd_id == id_in) begin
          if (item_r.mode == ModeAdd) begin
            wr_en = 1'b1;
            wr_data = {rd_id, (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt
                                                             : rd_cnt + 1'b1};
          end else if (rd_cnt > COUNT_BITS'(1)) begin
            wr_en = 1'b1;
            wr_data = {rd_id, rd_cnt - 1'b1};
          end
        end else if (!rd_wait_r && idx_ext + 1'b1 >= len_r
                     && item_r.mode == ModeAdd && len_r < LW'(MAX_CONFIGS)) begin
          wr_en = 1'b1;
          wr_addr = AW'(len_r);
          wr_data = {id_in, COUNT_BITS'(1)};
        end
        if (rd_wait_r) rd_addr = idx_r;
        else rd_addr = idx_r + 1'b1;
      end
      S_SHIFT, S_ROTATE: begin
        rd_addr = idx_r;
        if (!rd_wait_r) begin
          wr_en = 1'b1;
          wr_addr = idx_r - 1'b1;
          wr_data = rd_data;
        end
      end
      S_FRONT: begin
        rd_addr = '0;
        // The old front goes to the back once the rest has moved up.
        if (!rd_wait_r && item_r.mode == ModeResume) begin
          wr_en = 1'b1;
          wr_addr = AW'(len_r - 1'b1);
          wr_data = hold_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      timeslice_r <= 32'd1;
      kill_mode_r <= 1'b0;
      len_r <= '0;
      sched_v_r <= 1'b0;
      sched_id_r <= '0;
      act_v_r <= 1'b0;
      act_id_r <= '0;
      rem_r <= '0;
      last_r <= '1;
      idx_r <= '0;
      rd_wait_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegTimeslice: timeslice_r <= cfg_data;
          RegKillMode:  kill_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      rd_wait_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r <= in_data;
            res_r <= '0;
            idx_r <= '0;
            rd_wait_r <= 1'b1;
            state_r <= S_DONE;
            unique case (in_data.mode)
              ModeAdd, ModeFinish: begin
                if (len_r == '0) begin
                  if (in_data.mode == ModeAdd) begin
                    state_r <= S_SEARCH;
                  end else begin
                    res_r.status <= StatNotFound;
                  end
                end else begin
                  state_r <= S_SEARCH;
                end
              end
              // Charge first; a due switch rotates the ring.
              ModeSched:   state_r <= S_DONE;
              ModePreempt: state_r <= S_DONE;
              ModeResume:  state_r <= S_DONE;
              default:     state_r <= S_DONE;
            endcase
          end
        end
        S_SEARCH: begin
          if (!rd_wait_r) begin
            if (len_r != '0 && rd_id == id_in) begin
              if (item_r.mode == ModeFinish && rd_cnt <= COUNT_BITS'(1)) begin
                if (sched_v_r && sched_id_r == id_in) sched_v_r <= 1'b0;
                if (idx_ext + 1'b1 >= len_r) begin
                  len_r <= len_r - 1'b1;
                  state_r <= S_DONE;
                end else begin
                  idx_r <= idx_r + 1'b1;
                  rd_wait_r <= 1'b1;
                  state_r <= S_SHIFT;
                end
              end else begin
                state_r <= S_DONE;
              end
            end else if (len_r == '0 || idx_ext + 1'b1 >= len_r) begin
              if (item_r.mode == ModeAdd) begin
                if (len_r < LW'(MAX_CONFIGS)) len_r <= len_r + 1'b1;
                else res_r.status <= StatFull;
              end else begin
                res_r.status <= StatNotFound;
              end
              state_r <= S_DONE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_SHIFT: begin
          if (!rd_wait_r) begin
            if (idx_ext + 1'b1 >= len_r) begin
              len_r <= len_r - 1'b1;
              state_r <= S_DONE;
            end else begin
              idx_r <= idx_r + 1'b1;
              rd_wait_r <= 1'b1;
            end
          end
        end
        S_FRONT: begin
          // First pass reads entry 0 to hold; after rotation it reads the new front.
          if (!rd_wait_r) begin
            if (item_r.mode == ModeSched) begin
              hold_r <= rd_data;
              if (len_r == LW'(1)) begin
                item_r.mode <= ModeResume;
                rd_wait_r <= 1'b1;
              end else begin
                idx_r <= AW'(1);
                rd_wait_r <= 1'b1;
                state_r <= S_ROTATE;
              end
            end else begin
              sched_v_r <= 1'b1;
              sched_id_r <= rd_id;
              act_v_r <= 1'b1;
              act_id_r <= rd_id;
              res_r.issued <= 1'b1;
              res_r.next_config <= 8'(rd_id);
              if (act_v_r && act_id_r != rd_id) last_r <= sat50(ovh);
              rem_r <= signed'({18'd0, timeslice_r});
              out_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        S_ROTATE: begin
          if (!rd_wait_r) begin
            if (idx_ext + 1'b1 >= len_r) begin
              item_r.mode <= ModeResume;
              idx_r <= '0;
              rd_wait_r <= 1'b1;
              state_r <= S_FRONT;
            end else begin
              idx_r <= idx_r + 1'b1;
              rd_wait_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (item_r.mode == ModeSched) begin
            rem_r <= charged;
            last_r <= signed'({2'b0, item_r.now});
            if (len_r != '0) begin
              res_r.wait_valid <= 1'b1;
              res_r.wait_time <= timeslice_r;
            end
            if ((charged <= 0 || !sched_v_r) && len_r != '0) begin
              idx_r <= '0;
              rd_wait_r <= 1'b1;
              state_r <= S_FRONT;
            end else begin
              out_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            if (item_r.mode == ModeFinish) begin
              res_r.wake_component <= !sched_v_r && len_r != '0;
            end else if (item_r.mode == ModePreempt) begin
              rem_r <= charged;
            end else if (item_r.mode == ModeResume) begin
              last_r <= signed'({2'b0, item_r.now});
            end
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/rrcs_checker.sv
// Port-level checker for the round-robin configuration scheduler.
// Depends on rrcs_pkg; bound to the top level at the end of this file.
module rrcs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input rrcs_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_stall
);
  import rrcs_pkg::*;

  // A result is held while the consumer stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // No new item is taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted with result pending");

  // Issued id is zero when nothing is issued.
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.issued |-> out_data.next_config == '0)
    else $error("next_config set without issue");

  // An issued result always carries a wait time and an Ok status.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.issued |-> out_data.wait_valid && out_data.status == StatOk)
    else $error("issued result inconsistent");
endmodule

bind round_robin_config_scheduler rrcs_checker u_rrcs_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);

// File: test/tb_round_robin_config_scheduler.sv
// Testbench for round_robin_config_scheduler: directed and random items through the
// valid/stall channels, checked against an in-bench model of the scheduler ring.
// Depends on rrcs_pkg and the scheduler RTL.
module tb_round_robin_config_scheduler;
  import rrcs_pkg::*;

  localparam int RingDepth = 16;
  localparam int CountMax = 255;
  localparam longint SliceMax = (64'sd1 <<< 49) - 1;
  localparam longint SliceMin = -(64'sd1 <<< 49);

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [31:0] cfg_data;

  round_robin_config_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int phase = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  // Scheduler model state.
  logic [31:0] m_timeslice;
  logic m_kill;
  logic [7:0] m_ids[RingDepth];
  logic [7:0] m_counts[RingDepth];
  int m_len;
  logic m_sched_valid;
  logic [7:0] m_sched_id;
  logic m_act_valid;
  logic [7:0] m_act_id;
  longint m_remaining;
  longint m_last_assign;

  task automatic add_pending(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic longint sat_time(longint v);
    if (v > SliceMax) return SliceMax;
    if (v < SliceMin) return SliceMin;
    return v;
  endfunction

  function automatic int ring_find(logic [7:0] id);
    for (int i = 0; i < m_len; i++) if (m_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic out_item_t schedule_item(in_item_t it);
    out_item_t r;
    int pos;
    logic [7:0] fid;
    logic [7:0] fcnt;
    logic due;
    longint nw;
    longint t;
    r = '0;
    nw = longint'(it.now);
    case (it.mode)
      ModeAdd: begin
        pos = ring_find(it.config_id);
        if (pos >= 0) begin
          if (m_counts[pos] < CountMax) m_counts[pos]++;
        end else if (m_len < RingDepth) begin
          m_ids[m_len] = it.config_id;
          m_counts[m_len] = 8'd1;
          m_len++;
        end else r.status = StatFull;
      end
      ModeFinish: begin
        pos = ring_find(it.config_id);
        if (pos < 0) r.status = StatNotFound;
        else if (m_counts[pos] <= 1) begin
          if (m_sched_valid && m_sched_id == it.config_id) m_sched_valid = 0;
          for (int i = pos; i + 1 < m_len; i++) begin
            m_ids[i] = m_ids[i+1];
            m_counts[i] = m_counts[i+1];
          end
          m_len--;
        end else m_counts[pos]--;
        r.wake_component = !m_sched_valid && m_len > 0;
      end
      ModeSched: begin
        m_remaining = sat_time(m_remaining - (nw - m_last_assign));
        m_last_assign = nw;
        due = m_remaining <= 0 || !m_sched_valid;
        if (m_len > 0) begin
          r.wait_valid = 1;
          r.wait_time = m_timeslice;
        end
        if (due && m_len > 0) begin
          fid = m_ids[0];
          fcnt = m_counts[0];
          for (int i = 0; i + 1 < m_len; i++) begin
            m_ids[i] = m_ids[i+1];
            m_counts[i] = m_counts[i+1];
          end
          m_ids[m_len-1] = fid;
          m_counts[m_len-1] = fcnt;
          m_sched_valid = 1;
          m_sched_id = m_ids[0];
          r.issued = 1;
          r.next_config = m_sched_id;
          if (m_act_valid && m_act_id != m_sched_id) begin
            t = nw + longint'(it.preempt_time) + longint'(it.resume_time)
                + longint'(it.load_time);
            if (!m_kill) t += longint'(it.store_time);
            m_last_assign = sat_time(t);
          end
          m_act_valid = 1;
          m_act_id = m_sched_id;
          m_remaining = longint'(m_timeslice);
        end
      end
      ModePreempt: m_remaining = sat_time(m_remaining - (nw - m_last_assign));
      ModeResume: m_last_assign = nw;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic bit sender_idles();
    return (phase == 1 && roll(86)) || (phase == 3 && roll(6));
  endfunction

  // Driver: a new item is taken from the queue only once the current one is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() > 0 && !sender_idles()) begin
        in_valid <= 1;
        in_data <= pending_items[0];
        pending_items.delete(0);
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 300;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= (phase == 2 && roll(86)) || (phase == 3 && roll(6));
    end
  end

  // Monitor: predict on input acceptance first, so a same-edge result still finds it.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), schedule_item(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_data.issued !== want.issued)
            report_mismatch("issued", out_data.issued, want.issued);
          if (out_data.next_config !== want.next_config)
            report_mismatch("next_config", out_data.next_config, want.next_config);
          if (out_data.wait_valid !== want.wait_valid)
            report_mismatch("wait_valid", out_data.wait_valid, want.wait_valid);
          if (out_data.wait_time !== want.wait_time)
            report_mismatch("wait_time", out_data.wait_time, want.wait_time);
          if (out_data.wake_component !== want.wake_component)
            report_mismatch("wake_component", out_data.wake_component, want.wake_component);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
      end
    end
  end

  longint unsigned time_cursor = 0;

  function automatic in_item_t make_item(logic [2:0] mode, logic [7:0] id);
    in_item_t it;
    int step;
    it.mode = mode;
    it.config_id = id;
    step = (m_timeslice < 200) ? int'(m_timeslice) * 3 + 2 : 400;
    time_cursor = (time_cursor + $urandom_range(step, 0)) & 48'hFFFF_FFFF_FFFF;
    it.now = time_cursor[47:0];
    if (roll(3)) it.now = 48'({$urandom, $urandom});
    else if (roll(2)) it.now = roll(50) ? 48'h0 : 48'hFFFF_FFFF_FFFF;
    if (roll(15)) begin
      it.preempt_time = $urandom;
      it.store_time = $urandom;
      it.resume_time = $urandom;
      it.load_time = $urandom;
    end else begin
      it.preempt_time = $urandom_range(40, 0);
      it.store_time = $urandom_range(40, 0);
      it.resume_time = $urandom_range(40, 0);
      it.load_time = $urandom_range(40, 0);
    end
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    logic [2:0] mode;
    logic [7:0] id;
    r = $urandom_range(99, 0);
    if (r < 30) mode = ModeAdd;
    else if (r < 55) mode = ModeFinish;
    else if (r < 80) mode = ModeSched;
    else if (r < 88) mode = ModePreempt;
    else if (r < 96) mode = ModeResume;
    else mode = 3'($urandom_range(7, 5));
    id = roll(85) ? 8'($urandom_range(20, 0)) : 8'($urandom);
    return make_item(mode, id);
  endfunction

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == RegTimeslice) m_timeslice = val;
    else m_kill = val[0];
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    m_timeslice = 1;
    m_kill = 0;
    m_len = 0;
    m_sched_valid = 0;
    m_sched_id = 0;
    m_act_valid = 0;
    m_act_id = 0;
    m_remaining = 0;
    m_last_assign = -1;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    // Directed: empty ring schedule, unknown finish, extremes, every mode.
    add_pending(make_item(ModeSched, 8'd0));
    add_pending(make_item(ModeFinish, 8'd9));
    add_pending(make_item(ModeAdd, 8'd0));
    add_pending(make_item(ModeAdd, 8'hFF));
    add_pending(make_item(ModeAdd, 8'hFF));
    add_pending(make_item(ModeSched, 8'd0));
    add_pending(make_item(ModeSched, 8'd0));
    add_pending(make_item(ModePreempt, 8'd0));
    add_pending(make_item(ModeResume, 8'd0));
    add_pending(make_item(ModeSched, 8'd0));
    add_pending(make_item(ModeFinish, 8'hFF));
    add_pending(make_item(ModeFinish, 8'hFF));
    add_pending(make_item(ModeSched, 8'd0));
    add_pending(make_item(3'd7, 8'hFF));
    add_pending(make_item(3'd5, 8'hAA));
    add_pending(make_item(ModeFinish, 8'd0));
    drain();

    for (int p = 0; p < 4; p++) begin
      phase = p;
      case (p)
        0: begin write_reg(RegTimeslice, 32'd5); write_reg(RegKillMode, 32'd1); end
        1: begin write_reg(RegTimeslice, 32'hFFFF_FFFF); write_reg(RegKillMode, 32'd0); end
        2: begin write_reg(RegTimeslice, 32'd1); write_reg(RegKillMode, 32'd1); end
        default: begin write_reg(RegTimeslice, 32'd60); write_reg(RegKillMode, 32'd0); end
      endcase
      // Fill the ring past capacity, and in the first phase drive one count to saturation.
      for (int i = 0; i < 18; i++) add_pending(make_item(ModeAdd, 8'(40 + i)));
      if (p == 0)
        for (int i = 0; i < 260; i++) add_pending(make_item(ModeAdd, 8'd40));
      for (int i = 0; i < 18; i++) begin
        add_pending(make_item(ModeSched, 8'd0));
        add_pending(make_item(ModeFinish, 8'(40 + i)));
      end
      for (int i = 0; i < 100; i++) add_pending(random_item());
      if (p == 0) hold_req = hold_req + 1;
      drain();
    end

    phase = 0;
    repeat (100) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rrcs_pkg.sv
rtl/core/rrcs_ring.sv
rtl/core/round_robin_config_scheduler.sv
rtl/core/rrcs_checker.sv
test/tb_round_robin_config_scheduler.sv
